### src/twwg_pkg.sv
package twwg_pkg;

  // field and datapath widths
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned NUM_W      = 14;
  localparam int unsigned DIV_W      = 14;
  localparam int unsigned TURN_W     = 24;
  localparam int unsigned NUM_HARM   = 4;
  localparam int unsigned CORD_STEPS = 16;
  localparam int unsigned CORD_W     = 33;
  localparam int unsigned CORD_FRAC  = 30;
  localparam int unsigned ZW         = 26;
  localparam int unsigned COS_W      = 18;
  localparam int unsigned COS_FRAC   = 15;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = COEF_W + COS_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned WSUM_W     = ACC_W + 2;
  localparam int unsigned WEIGHT_W   = 15;
  localparam int unsigned WEIGHT_FRAC = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // cordic gain folded into the start value, Q2.30
  localparam logic signed [CORD_W-1:0] CORD_START = 33'sd652032874;

  // arctangent of 2^-i in 2^-24 turn units
  localparam logic signed [ZW-1:0] ATAN_TURNS [CORD_STEPS] = '{
    26'sd2097152, 26'sd1238021, 26'sd654137, 26'sd332050,
    26'sd166669,  26'sd83416,   26'sd41718,  26'sd20860,
    26'sd10430,   26'sd5215,    26'sd2608,   26'sd1304,
    26'sd652,     26'sd326,     26'sd163,    26'sd81
  };

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_HARM] = '{
    16'sd11284, -16'sd498, 16'sd140, -16'sd24
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH     = 3'd0,
    CFG_COEF_ONE   = 3'd1,
    CFG_COEF_TWO   = 3'd2,
    CFG_COEF_THREE = 3'd3,
    CFG_COEF_FOUR  = 3'd4
  } cfg_idx_e;

  typedef logic [TURN_W-1:0]        turn_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [COS_W-1:0]  cos_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic bit_in,
                                              input logic [DIV_W-1:0] dvs);
    logic [DIV_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, dvs}) begin
      t = t - {1'b0, dvs};
      return {1'b1, t[DIV_W-1:0]};
    end
    return {1'b0, t[DIV_W-1:0]};
  endfunction

  // reduce a value below twice the divisor
  function automatic logic [DIV_W-1:0] cond_sub(input logic [DIV_W:0] x,
                                                input logic [DIV_W-1:0] dvs);
    logic [DIV_W:0] t;
    t = x;
    if (t >= {1'b0, dvs}) begin
      t = t - {1'b0, dvs};
    end
    return t[DIV_W-1:0];
  endfunction

endpackage

### src/twwg_phase.sv
module twwg_phase (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [twwg_pkg::IDX_W-1:0] idx_i,
  input  logic [twwg_pkg::LEN_W-1:0] len_i,
  output logic                       vld_o,
  output twwg_pkg::turn_t            turn_o [twwg_pkg::NUM_HARM]
);
  import twwg_pkg::*;

  localparam int unsigned MS = NUM_W;
  localparam int unsigned TS = TURN_W;

  // modulo stages: (2k + 1 + len) mod 2len
  logic [MS:0]        mvld_q;
  logic [NUM_W-1:0]   mnum_q [MS+1];
  logic [DIV_W-1:0]   mrem_q [MS+1];
  logic [DIV_W-1:0]   md_q   [MS+1];
  logic [LEN_W-1:0]   mlen_q [MS+1];
  logic [DIV_W:0]     mstep  [MS];

  // harmonic reduction stage
  logic               hvld_q;
  logic [DIV_W-1:0]   hbase_q, hr2_q, hd_q;
  logic [LEN_W-1:0]   hlen_q;

  // turn division stages, one quotient bit each
  logic [TS:0]        tvld_q;
  logic [DIV_W-1:0]   trem_q [NUM_HARM][TS+1];
  logic [TS-1:0]      tquo_q [NUM_HARM][TS+1];
  logic [DIV_W-1:0]   td_q   [TS+1];
  logic [LEN_W-1:0]   tlen_q [TS+1];
  logic [DIV_W:0]     tstep  [NUM_HARM][TS];
  logic [TS-1:0]      tlenx  [TS];

  // division step logic
  always_comb begin
    for (int j = 0; j < MS; j++) begin
      mstep[j] = div_step(mrem_q[j], mnum_q[j][MS-1-j], md_q[j]);
    end
    for (int s = 0; s < TS; s++) begin
      tlenx[s] = TS'(tlen_q[s]);
      for (int h = 0; h < NUM_HARM; h++) begin
        tstep[h][s] = div_step(trem_q[h][s], tlenx[s][TS-1-s], td_q[s]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= '0;
      hvld_q <= 1'b0;
      tvld_q <= '0;
    end else if (en_i) begin
      mvld_q <= {mvld_q[MS-1:0], vld_i};
      hvld_q <= mvld_q[MS];
      tvld_q <= {tvld_q[TS-1:0], hvld_q};
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mnum_q[0] <= NUM_W'({idx_i, 1'b1}) + NUM_W'(len_i);
      mrem_q[0] <= '0;
      md_q[0]   <= {len_i, 1'b0};
      mlen_q[0] <= len_i;
      for (int j = 0; j < MS; j++) begin
        mnum_q[j+1] <= mnum_q[j];
        mrem_q[j+1] <= mstep[j][DIV_W-1:0];
        md_q[j+1]   <= md_q[j];
        mlen_q[j+1] <= mlen_q[j];
      end
      hbase_q <= mrem_q[MS];
      hr2_q   <= cond_sub({mrem_q[MS], 1'b0}, md_q[MS]);
      hd_q    <= md_q[MS];
      hlen_q  <= mlen_q[MS];
      trem_q[0][0] <= hbase_q;
      trem_q[1][0] <= hr2_q;
      trem_q[2][0] <= cond_sub({1'b0, hr2_q} + {1'b0, hbase_q}, hd_q);
      trem_q[3][0] <= cond_sub({hr2_q, 1'b0}, hd_q);
      td_q[0]      <= hd_q;
      tlen_q[0]    <= hlen_q;
      for (int h = 0; h < NUM_HARM; h++) begin
        tquo_q[h][0] <= '0;
      end
      for (int s = 0; s < TS; s++) begin
        td_q[s+1]   <= td_q[s];
        tlen_q[s+1] <= tlen_q[s];
        for (int h = 0; h < NUM_HARM; h++) begin
          trem_q[h][s+1] <= tstep[h][s][DIV_W-1:0];
          tquo_q[h][s+1] <= {tquo_q[h][s][TS-2:0], tstep[h][s][DIV_W]};
        end
      end
    end
  end

  assign vld_o = tvld_q[TS];
  always_comb begin
    for (int h = 0; h < NUM_HARM; h++) begin
      turn_o[h] = tquo_q[h][TS];
    end
  end

endmodule

### src/twwg_cordic.sv
module twwg_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  twwg_pkg::turn_t turn_i,
  output logic            vld_o,
  output twwg_pkg::cos_t  cos_o
);
  import twwg_pkg::*;

  localparam int unsigned N = CORD_STEPS;
  localparam int unsigned RSH = CORD_FRAC - COS_FRAC;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << (TURN_W - 2));
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'd1 << (TURN_W - 1));
  localparam logic signed [ZW-1:0] Z_FULL    = ZW'(64'd1 << TURN_W);
  localparam logic signed [CORD_W-1:0] X_ROUND = CORD_W'(64'd1 << (RSH - 1));

  logic [N+1:0]              vld_q;
  logic signed [CORD_W-1:0]  x_q [N+1];
  logic signed [CORD_W-1:0]  y_q [N+1];
  logic signed [ZW-1:0]      z_q [N+1];
  logic [N:0]                flip_q;
  cos_t                      cos_q;

  logic signed [CORD_W-1:0]  x_d [N];
  logic signed [CORD_W-1:0]  y_d [N];
  logic signed [ZW-1:0]      z_d [N];
  logic signed [ZW-1:0]      zs, zf;
  logic                      flip_d;
  logic signed [CORD_W-1:0]  xa, xr, xc;

  // fold the angle into a quarter turn around zero
  always_comb begin
    zs = ZW'(turn_i);
    if (turn_i[TURN_W-1]) begin
      zs = zs - Z_FULL;
    end
    zf     = zs;
    flip_d = 1'b0;
    if (zs > Z_QUARTER) begin
      zf     = zs - Z_HALF;
      flip_d = 1'b1;
    end else if (zs < -Z_QUARTER) begin
      zf     = zs + Z_HALF;
      flip_d = 1'b1;
    end
  end

  // rotation steps
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (z_q[i] >= 0) begin
        x_d[i] = x_q[i] - (y_q[i] >>> i);
        y_d[i] = y_q[i] + (x_q[i] >>> i);
        z_d[i] = z_q[i] - ATAN_TURNS[i];
      end else begin
        x_d[i] = x_q[i] + (y_q[i] >>> i);
        y_d[i] = y_q[i] - (x_q[i] >>> i);
        z_d[i] = z_q[i] + ATAN_TURNS[i];
      end
    end
  end

  // round to q1.15 and apply the fold sign
  always_comb begin
    xa = x_q[N] + X_ROUND;
    xr = xa >>> RSH;
    xc = flip_q[N] ? -xr : xr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORD_START;
      y_q[0]    <= '0;
      z_q[0]    <= zf;
      flip_q[0] <= flip_d;
      for (int i = 0; i < N; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        flip_q[i+1] <= flip_q[i];
      end
      cos_q <= COS_W'(xc);
    end
  end

  assign vld_o = vld_q[N+1];
  assign cos_o = cos_q;

endmodule

### src/twwg_combine.sv
module twwg_combine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  twwg_pkg::cos_t                cos_i  [twwg_pkg::NUM_HARM],
  input  twwg_pkg::coef_t               coef_i [twwg_pkg::NUM_HARM],
  output logic                          vld_o,
  output logic [twwg_pkg::WEIGHT_W-1:0] weight_o
);
  import twwg_pkg::*;

  localparam int unsigned SH = 2 * WEIGHT_FRAC + 2 - WEIGHT_FRAC;
  localparam logic signed [WSUM_W-1:0] W_ONE   = WSUM_W'(64'd1 << CORD_FRAC);
  localparam logic signed [WSUM_W-1:0] W_ROUND = WSUM_W'(64'd1 << (SH - 1));
  localparam logic signed [WSUM_W-1:0] W_MAX   = WSUM_W'((64'd1 << WEIGHT_W) - 1);

  logic [2:0]                vld_q;
  logic signed [PROD_W-1:0]  prod_q [NUM_HARM];
  logic signed [ACC_W-1:0]   acc_q;
  logic [WEIGHT_W-1:0]       weight_q;

  logic signed [ACC_W-1:0]   acc_d;
  logic signed [WSUM_W-1:0]  wsum, wrnd;
  logic [WEIGHT_W-1:0]       weight_d;

  // exact sum of the harmonic terms
  always_comb begin
    acc_d = '0;
    for (int h = 0; h < NUM_HARM; h++) begin
      acc_d = acc_d + ACC_W'(prod_q[h]);
    end
  end

  // weight = 1 + 2 * sum, rounded to q1.14 and saturated
  always_comb begin
    wsum = W_ONE + (WSUM_W'(acc_q) <<< 1);
    wrnd = (wsum + W_ROUND) >>> SH;
    if (wsum < 0) begin
      weight_d = '0;
    end else if (wrnd > W_MAX) begin
      weight_d = W_MAX[WEIGHT_W-1:0];
    end else begin
      weight_d = wrnd[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int h = 0; h < NUM_HARM; h++) begin
        prod_q[h] <= PROD_W'(coef_i[h]) * PROD_W'(cos_i[h]);
      end
      acc_q    <= acc_d;
      weight_q <= weight_d;
    end
  end

  assign vld_o    = vld_q[2];
  assign weight_o = weight_q;

endmodule

### src/taylor_window_weight_generator_unit.sv
// Taylor window weight generator (nbar 5, -35 dB sidelobes).
// Input channel: in_valid_i / in_ready_o with sample_index_i (window index k).
// Output channel: out_valid_o / out_ready_i with weight_o, unsigned Q1.14.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge (0 window length, 1..4 coefficients F1..F4 in Q1.15); other
// indexes are ignored. Write only while no item is in flight.
// Throughput: one index per cycle while in_ready_o is high.
// Pipeline: 62 register stages, set by the 14 modulo steps and 24
// quotient steps of the phase divider and the 16 rotation steps of the
// cosine units.
// Stall: a two-entry output (last pipeline stage plus a skid register)
// lets one more item enter after the receiver stops; then the whole
// pipeline holds and in_ready_o drops until the skid register drains.
// Reset: clears all valid bits and loads the -35 dB design coefficients
// and a window length of 4096. A length of 0 acts as 1, and a length
// above MAX_LENGTH acts as MAX_LENGTH.
module taylor_window_weight_generator_unit #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [twwg_pkg::IDX_W-1:0]      sample_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [twwg_pkg::WEIGHT_W-1:0]   weight_o,
  input  logic                            cfg_we_i,
  input  logic [twwg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twwg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import twwg_pkg::*;

  logic [LEN_W-1:0]    len_q;
  coef_t               coef_q [NUM_HARM];
  logic [LEN_W-1:0]    len_c;
  logic                en;
  logic                ph_vld;
  turn_t               ph_turn [NUM_HARM];
  logic [NUM_HARM-1:0] co_vld;
  cos_t                co_cos [NUM_HARM];
  logic                pipe_vld;
  logic [WEIGHT_W-1:0] pipe_weight;
  logic                skid_vld_q;
  logic [WEIGHT_W-1:0] skid_weight_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      for (int h = 0; h < NUM_HARM; h++) begin
        coef_q[h] <= COEF_RESET[h];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LENGTH:     len_q     <= cfg_data_i[LEN_W-1:0];
        CFG_COEF_ONE:   coef_q[0] <= cfg_data_i;
        CFG_COEF_TWO:   coef_q[1] <= cfg_data_i;
        CFG_COEF_THREE: coef_q[2] <= cfg_data_i;
        CFG_COEF_FOUR:  coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // length limits
  always_comb begin
    if (len_q == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(len_q) > MAX_LENGTH) begin
      len_c = LEN_W'(MAX_LENGTH);
    end else begin
      len_c = len_q;
    end
  end

  // the pipeline advances whenever the skid register is free
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  twwg_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .idx_i  (sample_index_i),
    .len_i  (len_c),
    .vld_o  (ph_vld),
    .turn_o (ph_turn)
  );

  for (genvar h = 0; h < NUM_HARM; h++) begin : g_lane
    twwg_cordic u_cordic (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (ph_vld),
      .turn_i (ph_turn[h]),
      .vld_o  (co_vld[h]),
      .cos_o  (co_cos[h])
    );
  end

  twwg_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (&co_vld),
    .cos_i    (co_cos),
    .coef_i   (coef_q),
    .vld_o    (pipe_vld),
    .weight_o (pipe_weight)
  );

  // skid register catches the result when the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (pipe_vld && !out_ready_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_weight_q <= pipe_weight;
    end
  end

  assign out_valid_o = skid_vld_q || pipe_vld;
  assign weight_o    = skid_vld_q ? skid_weight_q : pipe_weight;

`ifndef NO_ASSERTIONS
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_ready_i |=> skid_vld_q && $stable(skid_weight_q))
    else $error("skid register lost its result");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(pipe_vld && !out_ready_i))
    else $error("skid register filled without a stalled result");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_c != '0 && 32'(len_c) <= MAX_LENGTH)
    else $error("effective window length out of range");
`endif

endmodule

### verif/taylor_window_weight_generator_unit_checker.sv
module taylor_window_weight_generator_unit_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [twwg_pkg::IDX_W-1:0]      sample_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [twwg_pkg::WEIGHT_W-1:0]   weight_i,
  input  logic                            cfg_we_i,
  input  logic [twwg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twwg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import twwg_pkg::*;

  localparam longint ATAN_TBL [16] = '{
    2097152, 1238021, 654137, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81
  };
  localparam int unsigned EXP_DEPTH = 256;

  logic [LEN_W-1:0]    win_len;
  coef_t               coefs [NUM_HARM];
  logic [WEIGHT_W-1:0] exp_mem [EXP_DEPTH];
  int unsigned         wr_cnt;
  int unsigned         rd_cnt;

  // floor division by 2^s
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // cordic cosine of a 2^-24 turn angle, rounded to Q1.15
  function automatic longint cordic_cos(longint ang);
    longint z, x, y, nx;
    bit     neg;
    z = ang & 64'hFF_FFFF;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z >= (1 << 23)) z -= (1 << 24);
    if (z > (1 << 22)) begin
      z -= (1 << 23);
      neg = 1;
    end else if (z < -(1 << 22)) begin
      z += (1 << 23);
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i);
        y  = y + fshr(x, i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + fshr(y, i);
        y  = y - fshr(x, i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    x = fshr(x + (1 << 14), 15);
    return neg ? -x : x;
  endfunction

  // taylor weight at index k for the current length and coefficients
  function automatic logic [WEIGHT_W-1:0] taylor_weight(logic [IDX_W-1:0] k);
    longint len, two_len, base, r, ang, acc, w;
    len = win_len;
    acc = 0;
    if (len == 0) len = 1;
    if (len > 4096) len = 4096;
    two_len = 2 * len;
    base = (2 * longint'(k) + 1 + len) % two_len;
    for (int m = 1; m <= 4; m++) begin
      r   = (m * base) % two_len;
      ang = ((r << 24) + len) / two_len;
      acc += longint'(coefs[m-1]) * cordic_cos(ang);
    end
    w = (64'sd1 << 30) + 2 * acc;
    if (w < 0) w = 0;
    else begin
      w = (w + (1 << 15)) >>> 16;
      if (w > 32767) w = 32767;
    end
    return w[WEIGHT_W-1:0];
  endfunction

  assign pending_o = wr_cnt - rd_cnt;

  // register shadow, predictions and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    logic [WEIGHT_W-1:0] exp_w;
    if (!rst_ni) begin
      win_len <= LEN_RESET;
      for (int i = 0; i < NUM_HARM; i++) coefs[i] <= COEF_RESET[i];
      wr_cnt <= 0;
      rd_cnt <= 0;
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        exp_mem[wr_cnt[7:0]] <= taylor_weight(sample_index_i);
        wr_cnt <= wr_cnt + 1;
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_cnt == rd_cnt) begin
          if (fail_count_o < 10) $display("unexpected weight transfer %0d", weight_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = exp_mem[rd_cnt[7:0]];
          rd_cnt <= rd_cnt + 1;
          if (exp_w !== weight_i) begin
            if (fail_count_o < 10)
              $display("weight mismatch: expected %0d actual %0d", exp_w, weight_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LENGTH:     win_len  <= cfg_data_i[LEN_W-1:0];
          CFG_COEF_ONE:   coefs[0] <= cfg_data_i;
          CFG_COEF_TWO:   coefs[1] <= cfg_data_i;
          CFG_COEF_THREE: coefs[2] <= cfg_data_i;
          CFG_COEF_FOUR:  coefs[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

### verif/taylor_window_weight_generator_unit_test.sv
module taylor_window_weight_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twwg_pkg::*;

  // register index outside the list, writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  in_valid_i = 0;
  logic                  in_ready_o;
  logic [IDX_W-1:0]      sample_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 0;
  logic [WEIGHT_W-1:0]   weight_o;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           cur_len;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  taylor_window_weight_generator_unit i_dut (.*);

  taylor_window_weight_generator_unit_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .sample_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .weight_i(weight_o), .cfg_we_i,
    .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_index(logic [IDX_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1;
    sample_index_i <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait for the pipeline to drain, then let it settle
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_LENGTH) cur_len = 32'(data);
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_coefs();
    write_reg(CFG_COEF_ONE, CFG_DATA_W'($urandom));
    write_reg(CFG_COEF_TWO, CFG_DATA_W'($urandom));
    write_reg(CFG_COEF_THREE, CFG_DATA_W'($urandom));
    write_reg(CFG_COEF_FOUR, CFG_DATA_W'($urandom));
  endtask

  // random indexes, mostly inside the window
  task automatic random_burst(int n);
    int top;
    top = (cur_len == 0) ? 0 : ((cur_len > 4096) ? 4095 : cur_len - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_index(IDX_W'($urandom));
      else send_index(IDX_W'($urandom_range(top)));
    end
  endtask

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int lens [8];
    lens = '{1, 2, 3, 64, 1000, 4096, 0, 8191};
    send_idle_pct = 11;
    recv_idle_pct = 51;
    cur_len = 4096;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset design, edges of the index and periodic continuation
    send_index(0);
    send_index(1);
    send_index(2047);
    send_index(2048);
    send_index(4095);
    drain();
    // saturation both ways and an odd length
    write_reg(CFG_LENGTH, 16'd7);
    write_reg(CFG_COEF_ONE, 16'h7FFF);
    write_reg(CFG_COEF_TWO, 16'h7FFF);
    write_reg(CFG_COEF_THREE, 16'h7FFF);
    write_reg(CFG_COEF_FOUR, 16'h7FFF);
    for (int k = 0; k < 7; k++) send_index(IDX_W'(k));
    send_index(12'hFFF);
    drain();
    write_reg(CFG_COEF_ONE, 16'h8000);
    write_reg(CFG_COEF_TWO, 16'h8000);
    write_reg(CFG_COEF_THREE, 16'h8000);
    write_reg(CFG_COEF_FOUR, 16'h8000);
    write_reg(CFG_NO_REG, 16'h1234);
    for (int k = 0; k < 7; k++) send_index(IDX_W'(k));
    drain();

    // random phases over lengths and idling patterns
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 51;
        recv_idle_pct = 11;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph % 3 == 0) write_reg(CFG_LENGTH, CFG_DATA_W'(lens[(ph / 3) % 8]));
      else write_reg(CFG_LENGTH, CFG_DATA_W'($urandom_range(4096)));
      if (ph % 4 == 0) begin
        write_reg(CFG_COEF_ONE, COEF_RESET[0]);
        write_reg(CFG_COEF_TWO, COEF_RESET[1]);
        write_reg(CFG_COEF_THREE, COEF_RESET[2]);
        write_reg(CFG_COEF_FOUR, COEF_RESET[3]);
      end else random_coefs();
      random_burst(65);
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
